[src/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[src/chdec_pkg.sv]
package chdec_pkg;

   // size line limits
   localparam int MAX_SIZE_DIGITS = 16;
   localparam int DIGIT_CNT_W     = 5;
   localparam int CHUNK_W         = 64;
   localparam int COUNT_W         = 24;

   // line feed byte
   localparam logic [7:0] LINE_FEED = 8'h0a;

   // end marker codes
   localparam logic [1:0] END_ZERO_CHUNK = 2'd0;
   localparam logic [1:0] END_INPUT_DONE = 2'd1;
   localparam logic [1:0] END_SIZE_LONG  = 2'd2;
   localparam logic [1:0] END_OUT_FULL   = 2'd3;

   // result queue sizing
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;
   localparam int RSP_SLACK = RSP_DEPTH / 2;

   // csr map
   localparam logic CSR_IDX_OUTPUT_LIMIT = 1'b0;
   localparam int   CSR_ADDR_W           = 3;

   typedef struct packed {
      logic                final_res;
      logic [COUNT_W-1:0]  bytes_out;
      logic [1:0]          end_code;
      logic                is_payload;
      logic [7:0]          out_byte;
   } rsp_item_type;

   // results produced by one request, marker always in item1 when two
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

[src/chdec_parser.sv]
`include "assert_macros.svh"

module chdec_parser
   import chdec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               last_byte,
   input  logic [COUNT_W-1:0] output_limit,
   output logic               busy,
   output rsp_push_type       push
);

   localparam logic [1:0] PH_SIZE      = 2'd0;
   localparam logic [1:0] PH_SIZE_LINE = 2'd1;
   localparam logic [1:0] PH_DATA      = 2'd2;
   localparam logic [1:0] PH_TRAILER   = 2'd3;

   // hex digit decode, bit 4 flags a valid digit
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;

   logic [1:0]             phase_ff, phase_in;
   logic [CHUNK_W-1:0]     remain_ff, remain_in;
   logic [DIGIT_CNT_W-1:0] digits_ff, digits_in;
   logic [COUNT_W-1:0]     emitted_ff, emitted_in;
   logic                   ended_ff, ended_in;

   logic [4:0]             hex;
   logic                   done;
   logic [1:0]             code;
   logic                   pay;
   rsp_item_type           pay_item;
   rsp_item_type           mark_item;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      if (accept) begin
         in_byte_ff <= in_byte;
         in_last_ff <= last_byte;
      end
   end

   assign busy = in_valid_ff;
   assign hex  = hex_decode(in_byte_ff);

   // decode step for the registered byte
   always_comb begin
      phase_in   = phase_ff;
      remain_in  = remain_ff;
      digits_in  = digits_ff;
      emitted_in = emitted_ff;
      ended_in   = ended_ff;
      done       = 1'b0;
      code       = END_ZERO_CHUNK;
      pay        = 1'b0;
      if (in_valid_ff && !ended_ff) begin
         unique case (phase_ff) inside
            PH_SIZE, PH_SIZE_LINE: begin
               if (phase_ff == PH_SIZE && hex[4]) begin
                  remain_in = {remain_ff[CHUNK_W-5:0], hex[3:0]};
                  digits_in = digits_ff + DIGIT_CNT_W'(1);
                  if (digits_in > DIGIT_CNT_W'(MAX_SIZE_DIGITS)) begin
                     done = 1'b1;
                     code = END_SIZE_LONG;
                  end
               end else begin
                  phase_in = PH_SIZE_LINE;
                  if (in_byte_ff == LINE_FEED) begin
                     if (remain_ff == '0) begin
                        done = 1'b1;
                        code = END_ZERO_CHUNK;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               if (emitted_ff >= output_limit) begin
                  done = 1'b1;
                  code = END_OUT_FULL;
               end else begin
                  pay        = 1'b1;
                  emitted_in = emitted_ff + COUNT_W'(1);
                  remain_in  = remain_ff - CHUNK_W'(1);
                  if (remain_ff == CHUNK_W'(1)) begin
                     phase_in = PH_TRAILER;
                  end
               end
            end
            default: begin
               if (in_byte_ff == LINE_FEED) begin
                  phase_in  = PH_SIZE;
                  remain_in = '0;
                  digits_in = '0;
               end
            end
         endcase
         if (!done && in_last_ff) begin
            done = 1'b1;
            code = END_INPUT_DONE;
         end
         if (done) begin
            ended_in = 1'b1;
         end
      end
      // a last byte re-arms for the next body
      if (in_valid_ff && in_last_ff) begin
         phase_in   = PH_SIZE;
         remain_in  = '0;
         digits_in  = '0;
         emitted_in = '0;
         ended_in   = 1'b0;
      end
   end

   // result items
   always_comb begin
      pay_item            = '0;
      pay_item.out_byte   = in_byte_ff;
      pay_item.is_payload = 1'b1;
      pay_item.bytes_out  = emitted_ff + COUNT_W'(1);
      mark_item           = '0;
      mark_item.end_code  = code;
      mark_item.final_res = 1'b1;
      mark_item.bytes_out = pay ? emitted_ff + COUNT_W'(1) : emitted_ff;
      push                = '0;
      if (pay && done) begin
         push.count = 2'd2;
         push.item0 = pay_item;
         push.item1 = mark_item;
      end else if (pay) begin
         push.count = 2'd1;
         push.item0 = pay_item;
      end else if (done) begin
         push.count = 2'd1;
         push.item0 = mark_item;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIZE;
         remain_ff  <= '0;
         digits_ff  <= '0;
         emitted_ff <= '0;
         ended_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         remain_ff  <= remain_in;
         digits_ff  <= digits_in;
         emitted_ff <= emitted_in;
         ended_ff   <= ended_in;
      end
   end

   `ASSERT_PROP(a_quiet_after_end, clock, reset, (in_valid_ff && ended_ff) |-> push.count == 2'd0)
   `ASSERT_PROP(a_pair_only_on_last, clock, reset, (push.count == 2'd2) |-> in_last_ff)
   `ASSERT_NEVER(a_digit_bound, clock, reset, digits_ff > DIGIT_CNT_W'(MAX_SIZE_DIGITS + 1))
   `ASSERT_PROP(a_no_push_when_idle, clock, reset, !in_valid_ff |-> push.count == 2'd0)

endmodule

[src/chdec_rsp_fifo.sv]
`include "assert_macros.svh"

module chdec_rsp_fifo
   import chdec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_push_type         push,
   input  logic                 pop,
   output logic                 not_empty,
   output rsp_item_type         head,
   output logic [RSP_CNT_W-1:0] level
);

   rsp_item_type           mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, rd_ff;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next;

   assign wr_next   = wr_ff + RSP_PTR_W'(1);
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];
   assign level     = count_ff;
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   // storage writes, up to two per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.item1;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + RSP_PTR_W'(push.count);
         rd_ff    <= rd_ff + RSP_PTR_W'(pop);
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, count_ff > RSP_CNT_W'(RSP_DEPTH))
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && count_ff == '0)
   `ASSERT_NEVER(a_push_fits, clock, reset, (RSP_CNT_W+1)'(count_ff) + (RSP_CNT_W+1)'(push.count) > (RSP_CNT_W+1)'(RSP_DEPTH))

endmodule

[src/http_chunked_body_decoder_top.sv]
// chunked body decoder
// request channel (req_): one raw body byte per request in req_tdata, with
// req_tlast on the final byte of the raw body.
// result channel (rsp_): decoded payload bytes, then one end marker per body
// flagged by rsp_tlast; rsp_tuser says whether a result is payload and, on
// the marker, why the body ended. rsp_tdata carries the byte and the running
// count of payload bytes.
// csr port: output_limit at byte address 0, caps payload bytes per body.
// throughput: one request per cycle while req_tready is high; a request may
// produce two results (a payload byte plus the end marker), so sustained
// output is one result per cycle while rsp_tready is high, with the result
// queue absorbing bursts. results pass the input register, then the
// eight-entry result queue, before they appear on rsp_tvalid.
// reset: decoder returns to reading a size line, queue is emptied and
// output_limit returns to its maximum.
// stall: while rsp_tready is low results wait in the queue; req_tready drops
// once the queue holds more than four results, or more than two while a
// request sits in the input register.
module http_chunked_body_decoder_top
   import chdec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: [7:0] in_byte
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // result: [7:0] out_byte, [31:8] bytes_out
   output logic [31:0]           rsp_tdata,
   // result: [0] is_payload, [2:1] end_code
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0]   limit_ff;
   logic                 csr_wr;
   logic                 busy;
   logic                 accept;
   rsp_push_type         push;
   rsp_item_type         head;
   logic [RSP_CNT_W-1:0] level;
   logic                 pop;

   // csr register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '1;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_OUTPUT_LIMIT) begin
         limit_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_OUTPUT_LIMIT) begin
         csr_prdata = {(32-COUNT_W)'(0), limit_ff};
      end
   end

   // flow control: room for two results per request in flight and accepted
   assign req_tready = ((RSP_CNT_W+1)'(level) + (busy ? (RSP_CNT_W+1)'(2) : '0))
                       <= (RSP_CNT_W+1)'(RSP_SLACK);
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   chdec_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_tdata),
      .last_byte    (req_tlast),
      .output_limit (limit_ff),
      .busy         (busy),
      .push         (push)
   );

   chdec_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .not_empty (rsp_tvalid),
      .head      (head),
      .level     (level)
   );

   // result packing
   assign rsp_tdata = {head.bytes_out, head.out_byte};
   assign rsp_tuser = {head.end_code, head.is_payload};
   assign rsp_tlast = head.final_res;

endmodule

[test/tb_http_chunked_body_decoder_top.sv]
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top;
   import chdec_pkg::*;

   localparam logic [7:0]            CARRIAGE_RETURN   = 8'h0d;
   localparam logic [1:0]            PAYLOAD_CODE      = 2'd0;
   localparam logic [23:0]           LIMIT_MAX         = 24'hFFFFFF;
   localparam logic [CSR_ADDR_W-1:0] OUTPUT_LIMIT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_OUTPUT_LIMIT);
   localparam int                    DRAIN_CYCLES      = 8;
   localparam int                    STALL_LIMIT       = 3000;
   localparam int                    IDLE_PERCENT      = 9;

   typedef enum logic [1:0] {
      DEC_SIZE,
      DEC_SIZE_LINE,
      DEC_DATA,
      DEC_TRAILER
   } decoder_phase_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   http_chunked_body_decoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // decoder state mirrored by the predictor
   decoder_phase_type dec_phase;
   logic [63:0]    dec_size_acc;
   logic [4:0]     dec_digits;
   logic [23:0]    dec_emitted;
   logic           dec_ended;
   logic [23:0]    dec_limit;

   rsp_item_type   pending_results[$];
   logic [7:0]     body_q[$];

   int  mismatch_count = 0;
   int  bytes_decoded  = 0;
   int  requests_sent  = 0;
   int  results_seen   = 0;
   int  ends_seen[4]   = '{0, 0, 0, 0};
   int  rsp_hold_cycles = 0;
   bit  steady_flow    = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void log_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function automatic void rearm_decoder();
      dec_phase    = DEC_SIZE;
      dec_size_acc = '0;
      dec_digits   = '0;
      dec_emitted  = '0;
      dec_ended    = 1'b0;
   endfunction

   function automatic void push_result(logic [7:0] b, logic pay, logic [1:0] code, logic fin);
      rsp_item_type r;
      r.out_byte   = b;
      r.is_payload = pay;
      r.end_code   = code;
      r.bytes_out  = dec_emitted;
      r.final_res  = fin;
      pending_results.push_back(r);
   endfunction

   // expected results of one accepted request
   function automatic void decode_byte(logic [7:0] b, logic last);
      int         h;
      logic       done;
      logic [1:0] code;
      h    = hex_value(b);
      done = 1'b0;
      code = END_ZERO_CHUNK;
      if (dec_ended) begin
         if (last) rearm_decoder();
         return;
      end
      bytes_decoded++;
      case (dec_phase) inside
         DEC_SIZE, DEC_SIZE_LINE: begin
            if (dec_phase == DEC_SIZE && h >= 0) begin
               dec_size_acc = {dec_size_acc[59:0], 4'(h)};
               dec_digits   = dec_digits + 5'd1;
               if (dec_digits > MAX_SIZE_DIGITS) begin
                  done = 1'b1;
                  code = END_SIZE_LONG;
               end
            end else begin
               // first non-digit belongs to the rest of the size line
               dec_phase = DEC_SIZE_LINE;
               if (b == LINE_FEED) begin
                  if (dec_size_acc == 0) begin
                     done = 1'b1;
                     code = END_ZERO_CHUNK;
                  end else begin
                     dec_phase = DEC_DATA;
                  end
               end
            end
         end
         DEC_DATA: begin
            if (dec_emitted >= dec_limit) begin
               done = 1'b1;
               code = END_OUT_FULL;
            end else begin
               dec_emitted = dec_emitted + 24'd1;
               push_result(b, 1'b1, PAYLOAD_CODE, 1'b0);
               dec_size_acc = dec_size_acc - 64'd1;
               if (dec_size_acc == 0) dec_phase = DEC_TRAILER;
            end
         end
         default: begin
            if (b == LINE_FEED) begin
               dec_phase    = DEC_SIZE;
               dec_size_acc = '0;
               dec_digits   = '0;
            end
         end
      endcase
      if (!done && last) begin
         done = 1'b1;
         code = END_INPUT_DONE;
      end
      if (done) begin
         push_result(8'h00, 1'b0, code, 1'b1);
         if (last) rearm_decoder();
         else dec_ended = 1'b1;
      end
   endfunction

   // send one request, sometimes with a random idle gap in front of it
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, last);
      requests_sent++;
   endtask

   // stop sending and let every expected result arrive
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write output_limit and read it back
   task automatic write_output_limit(input logic [23:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= OUTPUT_LIMIT_ADDR;
      csr_pwdata  <= {8'h00, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      dec_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {8'h00, dec_limit}) begin
         log_failure($sformatf("output_limit read %h, expected %h", csr_prdata, dec_limit));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // body builders
   function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
      if (nib < 10) return 8'h30 + 8'(nib);
      return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] non_lf_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == LINE_FEED) b = ";";
      return b;
   endfunction

   function automatic void add_line_end(int max_junk);
      repeat ($urandom_range(max_junk)) body_q.push_back(non_lf_byte());
      if ($urandom_range(9) < 7) body_q.push_back(CARRIAGE_RETURN);
      body_q.push_back(LINE_FEED);
   endfunction

   function automatic void add_size_line(logic [63:0] value, bit empty_ok);
      int nd;
      int r;
      nd = 1;
      while (nd < 16 && (value >> (4 * nd)) != 0) nd++;
      r = $urandom_range(9);
      if (r == 0) nd = 16;
      else if (r < 4) nd = nd + 1;
      if (nd > 16) nd = 16;
      if (empty_ok && $urandom_range(7) == 0) nd = 0;
      for (int i = nd - 1; i >= 0; i--) begin
         body_q.push_back(hex_char(value[4*i +: 4], 1'($urandom_range(1))));
      end
      // optional chunk extension
      if ($urandom_range(3) == 0) begin
         body_q.push_back(";");
         add_line_end(3);
      end else begin
         add_line_end(0);
      end
   endfunction

   function automatic void add_chunk(int size);
      add_size_line(64'(size), 1'b0);
      repeat (size) body_q.push_back(8'($urandom_range(255)));
      add_line_end($urandom_range(3) == 0 ? 2 : 0);
   endfunction

   function automatic void add_long_size();
      repeat ($urandom_range(19, 17)) begin
         body_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      end
      add_line_end(2);
   endfunction

   function automatic void add_noise(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(9);
         if (r < 4) body_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
         else if (r < 6) body_q.push_back(LINE_FEED);
         else body_q.push_back(8'($urandom_range(255)));
      end
   endfunction

   // one random body: mostly well formed, some cut short, too long or noise
   task automatic send_random_body();
      int kind;
      int cut;
      body_q.delete();
      kind = $urandom_range(99);
      if (kind < 85) begin
         repeat ($urandom_range(3)) add_chunk($urandom_range(16, 1));
      end
      if (kind >= 85) begin
         add_noise($urandom_range(12, 1));
      end else if (kind >= 75) begin
         add_long_size();
         add_noise($urandom_range(3));
      end else begin
         add_size_line(64'd0, 1'b1);
         if (kind < 60 && $urandom_range(3) == 0) add_noise($urandom_range(3, 1));
      end
      cut = body_q.size() - 1;
      if (kind >= 60 && kind < 75) cut = $urandom_range(body_q.size() - 1);
      for (int i = 0; i <= cut; i++) begin
         send_byte(body_q[i], i == cut);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.out_byte   = rsp_tdata[7:0];
         seen.bytes_out  = rsp_tdata[31:8];
         seen.is_payload = rsp_tuser[0];
         seen.end_code   = rsp_tuser[2:1];
         seen.final_res  = rsp_tlast;
         results_seen++;
         if (seen.final_res === 1'b1) ends_seen[seen.end_code]++;
         if (pending_results.size() == 0) begin
            log_failure($sformatf("unexpected result byte=%h pay=%b code=%0d count=%0d last=%b",
               seen.out_byte, seen.is_payload, seen.end_code, seen.bytes_out, seen.final_res));
         end else begin
            want = pending_results.pop_front();
            if (seen.out_byte !== want.out_byte || seen.is_payload !== want.is_payload ||
                seen.end_code !== want.end_code || seen.bytes_out !== want.bytes_out ||
                seen.final_res !== want.final_res) begin
               log_failure($sformatf(
                  "expected byte=%h pay=%b code=%0d count=%0d last=%b, got %h %b %0d %0d %b",
                  want.out_byte, want.is_payload, want.end_code, want.bytes_out,
                  want.final_res, seen.out_byte, seen.is_payload, seen.end_code,
                  seen.bytes_out, seen.final_res));
            end
         end
      end
   end

   // receiver: random stalls, long hold-offs on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
         STALL_LIMIT, pending_results.size());
      $display("tb_http_chunked_body_decoder_top: FAIL");
      $finish;
   end

   // chunks with extensions, empty zero line, bytes after the end, cut input
   task automatic test_basic_chunks();
      write_output_limit(LIMIT_MAX);
      send_byte("2", 1'b0);
      send_byte(";", 1'b0);
      send_byte(CARRIAGE_RETURN, 1'b0);
      send_byte(LINE_FEED, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CARRIAGE_RETURN, 1'b0);
      send_byte(LINE_FEED, 1'b0);
      send_byte("0", 1'b0);
      send_byte(LINE_FEED, 1'b0);
      // ignored after the end, last re-arms
      send_byte(LINE_FEED, 1'b1);
      // zero size line with no digits
      send_byte(LINE_FEED, 1'b0);
      send_byte(8'h7E, 1'b1);
      // last on a payload byte gives the byte and then the end
      send_byte("1", 1'b0);
      send_byte(LINE_FEED, 1'b0);
      send_byte(8'h80, 1'b1);
      // body end flagged last re-arms at once
      send_byte("0", 1'b0);
      send_byte(LINE_FEED, 1'b1);
      wait_drained();
   endtask

   // the seventeenth size digit ends the body
   task automatic test_size_digits();
      string digits;
      digits = "123456789ABCDEFab";
      for (int i = 0; i < digits.len(); i++) send_byte(digits[i], 1'b0);
      send_byte("Z", 1'b0);
      send_byte(LINE_FEED, 1'b1);
      wait_drained();
   endtask

   // output limit at zero and at a small value
   task automatic test_output_limit();
      write_output_limit(24'd0);
      send_byte("1", 1'b0);
      send_byte(LINE_FEED, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(LINE_FEED, 1'b1);
      wait_drained();
      write_output_limit(24'd2);
      send_byte("3", 1'b0);
      send_byte(LINE_FEED, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(LINE_FEED, 1'b1);
      wait_drained();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      write_output_limit(LIMIT_MAX);
      rsp_hold_cycles = 80;
      repeat (4) send_random_body();
      wait_drained();
   endtask

   task automatic test_random_bodies(input int count, input logic [23:0] limit, input bit steady);
      int start;
      write_output_limit(limit);
      steady_flow = steady;
      start = bytes_decoded;
      while (bytes_decoded - start < count) send_random_body();
      wait_drained();
      steady_flow = 1'b0;
   endtask

   initial begin
      rearm_decoder();
      dec_limit = LIMIT_MAX;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_chunks();
      test_size_digits();
      test_output_limit();
      test_backpressure();
      test_random_bodies(90, LIMIT_MAX, 1'b0);
      test_random_bodies(60, 24'($urandom_range(30, 1)), 1'b1);
      test_random_bodies(90, 24'hFFFFFE, 1'b0);
      wait_drained();

      $display("run covered %0d requests, %0d decoded bytes, %0d results checked",
         requests_sent, bytes_decoded, results_seen);
      $display("body ends: zero chunk %0d, input ran out %0d, size too long %0d, output full %0d",
         ends_seen[END_ZERO_CHUNK], ends_seen[END_INPUT_DONE],
         ends_seen[END_SIZE_LONG], ends_seen[END_OUT_FULL]);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_http_chunked_body_decoder_top: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_results.size());
         $display("tb_http_chunked_body_decoder_top: FAIL");
      end
      $finish;
   end

endmodule
